@@ hdl/lag_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lag_pkg
// Shared types and constants of the associated Laguerre evaluator.
// ----------------------------------------------------------------------------
package lag_pkg;

    localparam int DEG_W          = 6;
    localparam int ORD_W          = 6;
    localparam int PT_W           = 32;
    localparam int VAL_W          = 64;
    localparam int IDX_W          = 6;
    localparam int NUM_W          = 98;
    localparam int QUO_W          = 88;
    localparam int DIV_STEPS      = 8;
    localparam int DIV_STAGES     = QUO_W / DIV_STEPS;
    localparam int MAX_DEGREE_DEF = 31;

    localparam logic [VAL_W-1:0] ONE_Q32     = 64'h0000_0001_0000_0000;
    localparam logic [VAL_W-1:0] NEG_ONE_Q32 = 64'hFFFF_FFFF_0000_0000;

    // recurrence context, travels with each item around the loop
    typedef struct packed {
        logic [VAL_W-1:0] v1;
        logic [VAL_W-1:0] v2;
        logic [ORD_W-1:0] m;
        logic [PT_W-1:0]  x;
        logic [IDX_W-1:0] n;
        logic [IDX_W-1:0] i;
        logic             sat;
    } t_ctx;

endpackage
`default_nettype wire

@@ hdl/lag_num.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lag_num
// Four-stage numerator unit: (m+2i-1-x)*v1 - (m+i-1)*v2*2^16, exact.
// ----------------------------------------------------------------------------
module lag_num (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire lag_pkg::t_ctx  i_ctx,
    output logic                o_valid,
    output lag_pkg::t_ctx       o_ctx,
    output logic [lag_pkg::NUM_W-1:0] o_num
);
    import lag_pkg::*;

    logic [7:0]  w_k;
    logic [33:0] w_a;
    logic [33:0] w_a_neg;
    logic [6:0]  w_c;

    logic        r1_valid;
    t_ctx        r1_ctx;
    logic [31:0] r1_mag_a;
    logic [63:0] r1_mag_v1;
    logic [63:0] r1_mag_v2;
    logic [6:0]  r1_c;
    logic        r1_neg1;
    logic        r1_v2neg;

    logic        r2_valid;
    t_ctx        r2_ctx;
    logic [63:0] r2_p_lo;
    logic [63:0] r2_p_hi;
    logic [70:0] r2_t2;
    logic        r2_neg1;
    logic        r2_v2neg;

    logic        r3_valid;
    t_ctx        r3_ctx;
    logic [95:0] r3_t1;
    logic [NUM_W-1:0] r3_t2s;
    logic        r3_neg1;

    logic        r4_valid;
    t_ctx        r4_ctx;
    logic [NUM_W-1:0] r4_num;

    logic [NUM_W-1:0] n_t2;

    assign w_k     = 8'(i_ctx.m) + {1'b0, i_ctx.i, 1'b0} - 8'd1;
    assign w_a     = {10'd0, w_k, 16'd0} - {{2{i_ctx.x[31]}}, i_ctx.x};
    assign w_a_neg = 34'd0 - w_a;
    assign w_c     = 7'(i_ctx.m) + 7'(i_ctx.i) - 7'd1;
    assign n_t2    = {11'd0, r2_t2, 16'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ctx    <= i_ctx;
            r1_mag_a  <= w_a[33] ? w_a_neg[31:0] : w_a[31:0];
            r1_mag_v1 <= i_ctx.v1[63] ? (64'd0 - i_ctx.v1) : i_ctx.v1;
            r1_mag_v2 <= i_ctx.v2[63] ? (64'd0 - i_ctx.v2) : i_ctx.v2;
            r1_c      <= w_c;
            r1_neg1   <= w_a[33] ^ i_ctx.v1[63];
            r1_v2neg  <= i_ctx.v2[63];

            r2_ctx    <= r1_ctx;
            r2_p_lo   <= 64'(r1_mag_a) * 64'(r1_mag_v1[31:0]);
            r2_p_hi   <= 64'(r1_mag_a) * 64'(r1_mag_v1[63:32]);
            r2_t2     <= 71'(r1_mag_v2) * 71'(r1_c);
            r2_neg1   <= r1_neg1;
            r2_v2neg  <= r1_v2neg;

            r3_ctx    <= r2_ctx;
            r3_t1     <= {32'd0, r2_p_lo} + {r2_p_hi, 32'd0};
            // the v2 term enters with the opposite sign
            r3_t2s    <= r2_v2neg ? n_t2 : (NUM_W'(0) - n_t2);
            r3_neg1   <= r2_neg1;

            r4_ctx    <= r3_ctx;
            r4_num    <= r3_neg1 ? (r3_t2s - {2'd0, r3_t1}) : (r3_t2s + {2'd0, r3_t1});
        end
    end

    assign o_valid = r4_valid;
    assign o_ctx   = r4_ctx;
    assign o_num   = r4_num;

endmodule
`default_nettype wire

@@ hdl/lag_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lag_div
// Pipelined restoring divider: |num| / 2^16 / i, eight quotient bits a stage.
// ----------------------------------------------------------------------------
module lag_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire lag_pkg::t_ctx  i_ctx,
    input  wire logic [lag_pkg::NUM_W-1:0] i_num,
    output logic                o_valid,
    output lag_pkg::t_ctx       o_ctx,
    output logic                o_neg,
    output logic [lag_pkg::QUO_W-1:0] o_quo
);
    import lag_pkg::*;

    logic             r_valid [DIV_STAGES+1];
    t_ctx             r_ctx   [DIV_STAGES+1];
    logic             r_neg   [DIV_STAGES+1];
    logic [QUO_W-1:0] r_w     [DIV_STAGES+1];
    logic [IDX_W-1:0] r_rem   [DIV_STAGES+1];

    logic [NUM_W-1:0] w_mag;

    assign w_mag = i_num[NUM_W-1] ? (NUM_W'(0) - i_num) : i_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx[0] <= i_ctx;
            r_neg[0] <= i_num[NUM_W-1];
            r_w[0]   <= QUO_W'(w_mag[NUM_W-1:16]);
            r_rem[0] <= '0;
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [QUO_W-1:0] n_w;
        logic [IDX_W-1:0] n_rem;

        always_comb begin
            logic [IDX_W:0]   cur;
            logic [QUO_W-1:0] wt;
            logic [IDX_W-1:0] rt;
            wt = r_w[s];
            rt = r_rem[s];
            for (int k = 0; k < DIV_STEPS; k++) begin
                cur = {rt, wt[QUO_W-1]};
                wt  = {wt[QUO_W-2:0], 1'b0};
                if (cur >= {1'b0, r_ctx[s].i}) begin
                    rt    = IDX_W'(cur - {1'b0, r_ctx[s].i});
                    wt[0] = 1'b1;
                end else begin
                    rt = cur[IDX_W-1:0];
                end
            end
            n_w   = wt;
            n_rem = rt;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[s+1] <= r_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx[s+1] <= r_ctx[s];
                r_neg[s+1] <= r_neg[s];
                r_w[s+1]   <= n_w;
                r_rem[s+1] <= n_rem;
            end
        end
    end

    assign o_valid = r_valid[DIV_STAGES];
    assign o_ctx   = r_ctx[DIV_STAGES];
    assign o_neg   = r_neg[DIV_STAGES];
    assign o_quo   = r_w[DIV_STAGES];

endmodule
`default_nettype wire

@@ hdl/associated_laguerre_eval.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// associated_laguerre_eval
// L_n^m(x) by the three-term upward recurrence in signed Q32.32.
//
//  channel      dir  data                                       user
//  s_axis       in   [5:0] degree, [11:6] order, [43:12] point  -
//  m_axis       out  [63:0] value                               [0] overflow
//
// one recurrence step is an 18-stage loop (entry, 4 numerator stages,
// 12 divider stages, update); every item makes max(MAX_DEGREE,2)-1 laps
// before its result goes to the output register.
// up to 18 items share the loop; a new item is taken only when none recirculates.
// results leave in input order; a stalled output freezes the whole loop.
// reset is synchronous and clears all valid bits.
// ----------------------------------------------------------------------------
module associated_laguerre_eval #(
    parameter int MAX_DEGREE = lag_pkg::MAX_DEGREE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,   // degree, order, point
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,   // value
    output logic             o_m_axis_tuser    // overflow
);
    import lag_pkg::*;

    localparam int I_LAST = (MAX_DEGREE < 2) ? 2 : MAX_DEGREE;
    localparam logic [IDX_W-1:0] I_LAST_V = IDX_W'(I_LAST);
    localparam logic [IDX_W-1:0] MAX_V    = IDX_W'(MAX_DEGREE);

    logic             w_en;
    logic             w_recirc;
    logic [DEG_W-1:0] w_deg;
    t_ctx             w_new;

    logic             r_s0_valid;
    t_ctx             r_s0_ctx;

    logic             w_num_valid;
    t_ctx             w_num_ctx;
    logic [NUM_W-1:0] w_num;

    logic             w_div_valid;
    t_ctx             w_div_ctx;
    logic             w_div_neg;
    logic [QUO_W-1:0] w_quo;

    logic             w_ovf;
    logic [VAL_W-1:0] w_res;
    t_ctx             n_fin_ctx;

    logic             r_fin_valid;
    logic             r_fin_done;
    t_ctx             r_fin_ctx;

    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_value;
    logic             r_out_ovf;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign w_recirc        = r_fin_valid && !r_fin_done;
    assign o_s_axis_tready = w_en && !w_recirc;

    // start context: v0 = 1, v1 = m+1-x; degrees below one get a fixed value
    assign w_deg = i_s_axis_tdata[5:0];
    always_comb begin
        w_new.m   = i_s_axis_tdata[11:6];
        w_new.x   = i_s_axis_tdata[43:12];
        w_new.v2  = ONE_Q32;
        w_new.i   = IDX_W'(2);
        w_new.sat = 1'b0;
        if (w_deg[DEG_W-1]) begin
            w_new.v1 = NEG_ONE_Q32;
            w_new.n  = IDX_W'(1);
        end else if (w_deg == '0) begin
            w_new.v1 = ONE_Q32;
            w_new.n  = IDX_W'(1);
        end else begin
            w_new.v1 = {25'd0, 7'(w_new.m) + 7'd1, 32'd0}
                     - {{16{w_new.x[31]}}, w_new.x, 16'd0};
            w_new.n  = (w_deg > MAX_V) ? MAX_V : w_deg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= w_recirc || i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_ctx <= w_recirc ? r_fin_ctx : w_new;
        end
    end

    lag_num u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s0_valid),
        .i_ctx   (r_s0_ctx),
        .o_valid (w_num_valid),
        .o_ctx   (w_num_ctx),
        .o_num   (w_num)
    );

    lag_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_num_valid),
        .i_ctx   (w_num_ctx),
        .i_num   (w_num),
        .o_valid (w_div_valid),
        .o_ctx   (w_div_ctx),
        .o_neg   (w_div_neg),
        .o_quo   (w_quo)
    );

    // saturate the quotient to the signed 64-bit range
    always_comb begin
        if (!w_div_neg) begin
            w_ovf = (w_quo[QUO_W-1:63] != '0);
            w_res = w_ovf ? 64'h7FFF_FFFF_FFFF_FFFF : w_quo[63:0];
        end else begin
            w_ovf = (w_quo[QUO_W-1:64] != '0) || (w_quo[63] && (w_quo[62:0] != '0));
            w_res = w_ovf ? 64'h8000_0000_0000_0000 : (64'd0 - w_quo[63:0]);
        end
    end

    always_comb begin
        n_fin_ctx = w_div_ctx;
        // steps past the item's degree leave the values as they are
        if (w_div_ctx.i <= w_div_ctx.n) begin
            n_fin_ctx.v2  = w_div_ctx.v1;
            n_fin_ctx.v1  = w_res;
            n_fin_ctx.sat = w_div_ctx.sat | w_ovf;
        end
        n_fin_ctx.i = w_div_ctx.i + IDX_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_fin_valid <= w_div_valid;
            r_out_valid <= r_fin_valid && r_fin_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin_ctx   <= n_fin_ctx;
            r_fin_done  <= (w_div_ctx.i == I_LAST_V);
            r_out_value <= r_fin_ctx.v1;
            r_out_ovf   <= r_fin_ctx.sat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_ovf;

endmodule
`default_nettype wire
